FILE: sv/fpba_pkg.sv
package fpba_pkg;

    localparam int BLOCKS    = 32;
    localparam int SIZE_BITS = 16;

    localparam int IDX_W = $clog2(BLOCKS);
    localparam int CNT_W = $clog2(BLOCKS + 1);

    // stream field widths
    localparam int KIND_W   = 2;
    localparam int TDATA_W  = ((IDX_W + SIZE_BITS + 7) / 8) * 8;
    localparam int TPAD_W   = TDATA_W - IDX_W - SIZE_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RESET = CFG_DATA_W'(BLOCKS);

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd3;

    typedef struct packed {
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_addr;
        logic [SIZE_BITS-1:0] wr_data;
        logic                 rd_en;
        logic [IDX_W-1:0]     rd_addr;
    } tbl_req_t;

endpackage

FILE: sv/fit_policy_block_allocator.sv
// Block allocator with selectable fit policy (first, best, next, worst).
//
// Input stream s_*: tuser carries the item kind (load, request, read), tdata
// the block index and size. Output stream m_*: tuser is the grant flag, tdata
// the chosen block and its remaining free size. Exactly one result per item.
// Config channel cfg_*: index 0 sets the policy, index 1 the live block count
// (saturated to 32); write only while the block is idle. cfg_ready is always
// high.
//
// Sequence: a load or a rejected item goes straight to the result state, and a
// read passes through a table read first. A request runs the start-wrap step,
// scans the live blocks and, when granted, writes back the chosen block; first
// and next fit stop the scan once a block fits.
// One item is in the sequencer at a time; s_tready is high only while it is
// idle, and the next item can be taken in the cycle after a result moves out.
//
// Reset clears the sequencer, the next-fit pointer and the config (first fit,
// 32 blocks). The size table is not cleared: load a block before using it.
// A stalled receiver holds the result in the output register; the sequencer
// can finish the next item and waits with it until that register drains.
module fit_policy_block_allocator
    import fpba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // [4:0] block_index, [20:5] size
    input  logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [4:0] chosen_block, [20:5] remaining
    output logic                  m_tuser,   // [0] granted
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MODE_W-1:0]     fit_mode_reg;
    logic [CFG_DATA_W-1:0] block_count_reg;
    logic [CNT_W-1:0]      live_count;

    logic                  res_valid, res_ready;
    logic                  res_granted;
    logic [IDX_W-1:0]      res_block;
    logic [SIZE_BITS-1:0]  res_remaining;

    logic                  out_valid_reg;
    logic                  out_granted_reg;
    logic [IDX_W-1:0]      out_block_reg;
    logic [SIZE_BITS-1:0]  out_rem_reg;

    tbl_req_t              tbl_req;
    logic [SIZE_BITS-1:0]  tbl_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg    <= MODE_FIRST;
            block_count_reg <= BLOCK_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FIT_MODE:    fit_mode_reg    <= cfg_data[MODE_W-1:0];
                REG_BLOCK_COUNT: block_count_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign live_count = (block_count_reg > CFG_DATA_W'(BLOCKS))
                        ? CNT_W'(BLOCKS) : CNT_W'(block_count_reg);

    fpba_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_kind       (s_tuser),
        .in_index      (s_tdata[IDX_W-1:0]),
        .in_size       (s_tdata[IDX_W +: SIZE_BITS]),
        .fit_mode      (fit_mode_reg),
        .live_count    (live_count),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_granted   (res_granted),
        .res_block     (res_block),
        .res_remaining (res_remaining),
        .tbl_req       (tbl_req),
        .tbl_rd_data   (tbl_rd_data)
    );

    fpba_table u_table (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    // output register: loads whenever empty or draining this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_granted_reg <= res_granted;
            out_block_reg   <= res_block;
            out_rem_reg     <= res_remaining;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_granted_reg;
    assign m_tdata  = {{TPAD_W{1'b0}}, out_rem_reg, out_block_reg};

endmodule

FILE: sv/fpba_table.sv
module fpba_table
    import fpba_pkg::*;
(
    input  logic                 clk,
    input  tbl_req_t             req,
    output logic [SIZE_BITS-1:0] rd_data
);

    logic [SIZE_BITS-1:0] mem [BLOCKS];
    logic [SIZE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fpba_ctrl.sv
module fpba_ctrl
    import fpba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // item in
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KIND_W-1:0]    in_kind,
    input  logic [IDX_W-1:0]     in_index,
    input  logic [SIZE_BITS-1:0] in_size,
    // configuration
    input  logic [MODE_W-1:0]    fit_mode,
    input  logic [CNT_W-1:0]     live_count,
    // result out
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 res_granted,
    output logic [IDX_W-1:0]     res_block,
    output logic [SIZE_BITS-1:0] res_remaining,
    // table port
    output tbl_req_t             tbl_req,
    input  logic [SIZE_BITS-1:0] tbl_rd_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_MOD    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [IDX_W-1:0]     next_start_reg, next_start_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_val_reg, best_val_next;
    logic                 res_granted_reg, res_granted_next;
    logic [IDX_W-1:0]     res_block_reg, res_block_next;
    logic [SIZE_BITS-1:0] res_rem_reg, res_rem_next;

    logic                 early_stop;
    logic                 fits;
    logic                 better;
    logic [CNT_W-1:0]     k_inc;
    logic [CNT_W-1:0]     start_diff;
    logic [SIZE_BITS-1:0] new_size;

    assign early_stop = (fit_mode == MODE_FIRST) || (fit_mode == MODE_NEXT);
    assign fits       = tbl_rd_data >= size_reg;
    assign better     = !found_reg
                        || ((fit_mode == MODE_BEST)  && (tbl_rd_data < best_val_reg))
                        || ((fit_mode == MODE_WORST) && (tbl_rd_data > best_val_reg));
    assign k_inc      = {1'b0, k_reg} + CNT_W'(1);
    assign start_diff = {1'b0, k_reg} - n_reg;
    assign new_size   = best_val_reg - size_reg;

    always_comb
    begin
        state_next       = state_reg;
        size_next        = size_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        next_start_next  = next_start_reg;
        k_next           = k_reg;
        issue_cnt_next   = issue_cnt_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_val_next    = best_val_reg;
        res_granted_next = res_granted_reg;
        res_block_next   = res_block_reg;
        res_rem_next     = res_rem_reg;
        tbl_req          = '0;
        in_ready         = 1'b0;
        res_valid        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    size_next        = in_size;
                    idx_next         = in_index;
                    n_next           = live_count;
                    res_granted_next = 1'b0;
                    res_block_next   = '0;
                    res_rem_next     = '0;
                    state_next       = ST_RESULT;
                    case (in_kind)
                        KIND_LOAD:
                        begin
                            if ({1'b0, in_index} < live_count)
                            begin
                                tbl_req.wr_en    = 1'b1;
                                tbl_req.wr_addr  = in_index;
                                tbl_req.wr_data  = in_size;
                                next_start_next  = '0;
                                res_granted_next = 1'b1;
                                res_block_next   = in_index;
                                res_rem_next     = in_size;
                            end
                        end
                        KIND_READ:
                        begin
                            if ({1'b0, in_index} < live_count)
                            begin
                                tbl_req.rd_en   = 1'b1;
                                tbl_req.rd_addr = in_index;
                                state_next      = ST_READ;
                            end
                        end
                        KIND_REQUEST:
                        begin
                            if (live_count != '0)
                            begin
                                k_next     = next_start_reg;
                                state_next = ST_MOD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                res_granted_next = 1'b1;
                res_block_next   = idx_reg;
                res_rem_next     = tbl_rd_data;
                state_next       = ST_RESULT;
            end

            // bring a working copy of the next-fit start below the live count;
            // the pointer itself moves on a next-fit grant and is cleared by a load
            ST_MOD:
            begin
                if ({1'b0, k_reg} >= n_reg)
                begin
                    k_next = start_diff[IDX_W-1:0];
                end
                else
                begin
                    k_next         = (fit_mode == MODE_NEXT) ? k_reg : '0;
                    issue_cnt_next = '0;
                    found_next     = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            // one read issued and one entry compared per cycle
            ST_SCAN:
            begin
                if ((issue_cnt_reg != n_reg) && !(early_stop && found_reg))
                begin
                    tbl_req.rd_en  = 1'b1;
                    tbl_req.rd_addr = k_reg;
                    pend_next      = 1'b1;
                    pend_idx_next  = k_reg;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    k_next         = (k_inc == n_reg) ? '0 : k_inc[IDX_W-1:0];
                end
                if (pend_reg && !(early_stop && found_reg) && fits && better)
                begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_val_next = tbl_rd_data;
                end
                if (!pend_reg && ((issue_cnt_reg == n_reg) || (early_stop && found_reg)))
                begin
                    state_next = found_reg ? ST_WRITE : ST_RESULT;
                end
            end

            ST_WRITE:
            begin
                tbl_req.wr_en    = 1'b1;
                tbl_req.wr_addr  = best_idx_reg;
                tbl_req.wr_data  = new_size;
                if (fit_mode == MODE_NEXT)
                begin
                    next_start_next = best_idx_reg;
                end
                res_granted_next = 1'b1;
                res_block_next   = best_idx_reg;
                res_rem_next     = new_size;
                state_next       = ST_RESULT;
            end

            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            next_start_reg <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            issue_cnt_reg  <= '0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            next_start_reg <= next_start_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            issue_cnt_reg  <= issue_cnt_next;
            n_reg          <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg        <= size_next;
        idx_reg         <= idx_next;
        k_reg           <= k_next;
        pend_idx_reg    <= pend_idx_next;
        best_idx_reg    <= best_idx_next;
        best_val_reg    <= best_val_next;
        res_granted_reg <= res_granted_next;
        res_block_reg   <= res_block_next;
        res_rem_reg     <= res_rem_next;
    end

    assign res_granted   = res_granted_reg;
    assign res_block     = res_block_reg;
    assign res_remaining = res_rem_reg;

`ifndef ASSERT_OFF
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= n_reg))
        else $error("scan issued more reads than live blocks");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && found_reg) |-> ({1'b0, best_idx_reg} < n_reg))
        else $error("picked block outside live range");

    a_write_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (state_reg == ST_RESULT) && res_granted_reg)
        else $error("write-back not followed by granted result");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !res_valid && !pend_reg)
        else $error("input taken while an item is in flight");
`endif

endmodule
